FILE: rtl/pmq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pmq_pkg;

  // Slot count of the cell row.
  localparam int SLOTS   = 16;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = ($clog2(SLOTS + 1) > 5) ? $clog2(SLOTS + 1) : 5;

  localparam int PRIO_W  = 15;
  localparam int LEN_W   = 4;
  localparam int WORD_W  = 64;
  localparam int ORDER_W = 64;
  localparam int CAP_W   = 5;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 1;

  localparam logic [CAP_W-1:0] CAP_RESET    = 5'd10;
  localparam logic [LEN_W-1:0] MAXLEN_RESET = 4'd8;

  localparam logic [IDX_W-1:0] REG_CAPACITY   = 1'b0;
  localparam logic [IDX_W-1:0] REG_MAX_LENGTH = 1'b1;

  localparam logic CMD_SEND = 1'b0;
  localparam logic CMD_RECV = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BUSY    = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOSLOT  = 2'd3;

  // Best-so-far candidate handed from one cell to the next.
  typedef struct packed {
    logic               found;
    logic [PRIO_W-1:0]  prio;
    logic [ORDER_W-1:0] order;
    logic [SLOT_W-1:0]  idx;
  } cand_t;

  // Message contents held by one cell.
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
  } slot_t;

endpackage

`default_nettype wire

FILE: rtl/pmq_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module pmq_cell (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [pmq_pkg::SLOT_W-1:0]  cell_idx,
  input  wire logic                        wr,
  input  wire logic                        clr,
  input  wire pmq_pkg::slot_t              wr_slot,
  input  wire logic [pmq_pkg::ORDER_W-1:0] wr_order,
  input  wire pmq_pkg::cand_t              cand_in,
  output pmq_pkg::cand_t                   cand_out,
  output logic                             valid_o,
  output pmq_pkg::slot_t                   slot_o
);

  logic                        valid_r;
  pmq_pkg::slot_t              slot_r;
  logic [pmq_pkg::ORDER_W-1:0] order_r;
  pmq_pkg::cand_t              cand_r;
  pmq_pkg::cand_t              cand_nxt;
  logic                        beats_in;

  // Higher priority wins; on equal priority the older stamp wins. A tie on
  // both keeps the incoming candidate, which comes from a lower slot.
  always_comb begin
    beats_in = valid_r && (!cand_in.found ||
                           (slot_r.prio > cand_in.prio) ||
                           ((slot_r.prio == cand_in.prio) && (order_r < cand_in.order)));
    if (beats_in) begin
      cand_nxt.found = 1'b1;
      cand_nxt.prio  = slot_r.prio;
      cand_nxt.order = order_r;
      cand_nxt.idx   = cell_idx;
    end else begin
      cand_nxt = cand_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cand_r  <= '0;
    end else begin
      if (wr) begin
        valid_r <= 1'b1;
      end else if (clr) begin
        valid_r <= 1'b0;
      end
      cand_r <= cand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slot_r  <= wr_slot;
      order_r <= wr_order;
    end
  end

  assign cand_out = cand_r;
  assign valid_o  = valid_r;
  assign slot_o   = slot_r;

endmodule

`default_nettype wire

FILE: rtl/priority_message_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Results: a send, and any command answered with an error, gives its result beat in the cycle
//   after it is accepted; a receive that goes ahead gives its beat after the search and finish states.
// Commands: one send per cycle while the result stream takes each beat; no command is taken while
//   the wavefront of a receive walks the candidate through the row of slot cells, one cell per cycle.
// Reset (synchronous, rst_n low): all slots empty, count and order stamp zero, capacity 10,
//   max_length 8. Slot contents are not cleared and no clearing pass is run.

module priority_message_queue_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Configuration write port.
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [4:0]   cfg_wdata,
  // Command stream.
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [87:0]  in_tdata,   // priority_req[14:0], length[18:15], payload[82:19]
  input  wire logic [0:0]   in_tuser,   // command[0]
  // Result stream.
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [87:0]       out_tdata,  // out_priority[14:0], out_length[18:15],
                                        // out_payload[82:19], count[87:83]
  output logic [1:0]        out_tuser   // status[1:0]
);

  localparam int SLOTS  = pmq_pkg::SLOTS;
  localparam int SLOT_W = pmq_pkg::SLOT_W;
  localparam int CNT_W  = pmq_pkg::CNT_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  // Configuration registers.
  logic [pmq_pkg::CAP_W-1:0] cap_r;
  logic [pmq_pkg::LEN_W-1:0] maxlen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= pmq_pkg::CAP_RESET;
      maxlen_r <= pmq_pkg::MAXLEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmq_pkg::REG_CAPACITY:   cap_r    <= cfg_wdata;
        pmq_pkg::REG_MAX_LENGTH: maxlen_r <= cfg_wdata[pmq_pkg::LEN_W-1:0];
      endcase
    end
  end

  // Unpack the incoming beat.
  logic                        in_cmd;
  pmq_pkg::slot_t              in_slot;
  logic                        in_fire;

  assign in_cmd       = in_tuser[0];
  assign in_slot.prio = in_tdata[14:0];
  assign in_slot.len  = in_tdata[18:15];
  assign in_slot.word = in_tdata[82:19];

  // Control state.
  logic [1:0]                  state_r, state_nxt;
  logic [SLOT_W-1:0]           scan_r, scan_nxt;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic [pmq_pkg::ORDER_W-1:0] order_r, order_nxt;

  // The row of slot cells. The candidate enters cell 0 empty and each cell
  // passes on the better of what it receives and what it holds.
  pmq_pkg::cand_t cand_chain [SLOTS+1];
  pmq_pkg::slot_t slot_data  [SLOTS];
  logic [SLOTS-1:0] valid_vec;
  logic [SLOTS-1:0] wr_vec;
  logic [SLOTS-1:0] clr_vec;

  assign cand_chain[0] = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    pmq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (SLOT_W'(g)),
      .wr       (wr_vec[g]),
      .clr      (clr_vec[g]),
      .wr_slot  (in_slot),
      .wr_order (order_r),
      .cand_in  (cand_chain[g]),
      .cand_out (cand_chain[g+1]),
      .valid_o  (valid_vec[g]),
      .slot_o   (slot_data[g])
    );
  end

  // Free slots below the capacity; the lowest of them takes a send.
  logic [CNT_W-1:0] cap_ext;
  logic [CNT_W-1:0] eff_cap;
  logic [SLOTS-1:0] cap_mask;
  logic [SLOTS-1:0] free_vec;
  logic [SLOTS-1:0] pick_oh;

  assign cap_ext = CNT_W'(cap_r);
  assign eff_cap = (cap_ext < CNT_W'(SLOTS)) ? cap_ext : CNT_W'(SLOTS);

  for (genvar g = 0; g < SLOTS; g++) begin : g_mask
    assign cap_mask[g] = (CNT_W'(g) < cap_ext);
  end

  assign free_vec = ~valid_vec & cap_mask;
  assign pick_oh  = free_vec & (~free_vec + SLOTS'(1));

  // The candidate at the far end of the row names the message to receive.
  pmq_pkg::cand_t best;
  pmq_pkg::slot_t best_slot;

  assign best      = cand_chain[SLOTS];
  assign best_slot = slot_data[best.idx];

  // Result register.
  logic                        out_valid_r;
  logic [pmq_pkg::STAT_W-1:0]  out_status_r;
  pmq_pkg::slot_t              out_slot_r;
  logic [CNT_W-1:0]            out_count_r;

  logic                        load_out;
  logic [pmq_pkg::STAT_W-1:0]  res_status;
  pmq_pkg::slot_t              res_slot;

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt  = state_r;
    scan_nxt   = scan_r;
    count_nxt  = count_r;
    order_nxt  = order_r;
    wr_vec     = '0;
    clr_vec    = '0;
    load_out   = 1'b0;
    res_status = pmq_pkg::ST_OK;
    res_slot   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_cmd == pmq_pkg::CMD_SEND) begin
            load_out = 1'b1;
            if (in_slot.len > maxlen_r) begin
              res_status = pmq_pkg::ST_INVALID;
            end else if (count_r >= eff_cap) begin
              res_status = pmq_pkg::ST_BUSY;
            end else if (free_vec == '0) begin
              res_status = pmq_pkg::ST_NOSLOT;
            end else begin
              wr_vec    = pick_oh;
              order_nxt = order_r + 64'd1;
              count_nxt = count_r + CNT_W'(1);
            end
          end else begin
            if (in_slot.len < maxlen_r) begin
              load_out   = 1'b1;
              res_status = pmq_pkg::ST_INVALID;
            end else if (count_r == '0) begin
              load_out   = 1'b1;
              res_status = pmq_pkg::ST_BUSY;
            end else begin
              state_nxt = S_SEARCH;
              scan_nxt  = '0;
            end
          end
        end
      end
      S_SEARCH: begin
        // The slots last changed no later than the accepting edge, so once the
        // scan has stepped through every cell the far end of the row has settled.
        scan_nxt = scan_r + SLOT_W'(1);
        if (scan_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        load_out  = 1'b1;
        state_nxt = S_IDLE;
        if (best.found) begin
          res_slot         = best_slot;
          clr_vec[best.idx] = 1'b1;
          count_nxt        = count_r - CNT_W'(1);
        end else begin
          res_status = pmq_pkg::ST_NOSLOT;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      count_r     <= '0;
      order_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
      count_r <= count_nxt;
      order_r <= order_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_count_r  <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {out_count_r[4:0], out_slot_r.word, out_slot_r.len, out_slot_r.prio};

  // The message count always matches the number of occupied slots.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(count_r))
    else $error("message count differs from occupied slots");

  // The count never exceeds the slot count.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOTS))
    else $error("message count above slot count");

  // A finishing receive never overwrites a result that is still waiting.
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |-> !out_valid_r)
    else $error("result register busy at end of search");

  // A receive that has gone ahead always finds a message.
  a_finish_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH) |-> best.found)
    else $error("search ended without a candidate");

  // Slots are only emptied by a finishing receive.
  a_clear_only_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (clr_vec != '0) |-> (state_r == S_FINISH))
    else $error("slot cleared outside a receive");

endmodule

`default_nettype wire
